@@ hw/rtl/reno_pkg.sv @@
// Shared constants and types for the Reno congestion window core.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package reno_pkg;

  // Field widths
  localparam int unsigned MssW  = 16;
  localparam int unsigned WinW  = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned DupW  = 8;
  localparam int unsigned RtxW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Event commands
  localparam logic [CmdW-1:0] CMD_TIMEOUT = 2'd0;
  localparam logic [CmdW-1:0] CMD_NEW_ACK = 2'd1;
  localparam logic [CmdW-1:0] CMD_DUP_ACK = 2'd2;
  localparam logic [CmdW-1:0] CMD_START   = 2'd3;

  // Retransmit request codes
  localparam logic [RtxW-1:0] RTX_NONE    = 2'd0;
  localparam logic [RtxW-1:0] RTX_FAST    = 2'd1;
  localparam logic [RtxW-1:0] RTX_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MSS      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_WND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INIT_THR = 2'd2;

  // Configuration reset values
  localparam logic [MssW-1:0] MSS_RST      = 16'd536;
  localparam logic [WinW-1:0] INIT_WND_RST = 32'd536;
  localparam logic [WinW-1:0] INIT_THR_RST = 32'd65535;

  // Duplicate count that triggers fast retransmit
  localparam logic [DupW-1:0] DUP_THRESH = 8'd3;

  typedef struct packed {
    logic [MssW-1:0] mss;
    logic [WinW-1:0] init_wnd;
    logic [WinW-1:0] init_thr;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/reno_evt_if.sv @@
// Event request channel of the Reno congestion window core.
// Depends on reno_pkg for field widths.
`default_nettype none

interface reno_evt_if;
  import reno_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [DupW-1:0] dup_ack_count;
  logic [WinW-1:0] peer_window;
  logic            timeout_aborts;

  modport source (
    output valid, command, dup_ack_count, peer_window, timeout_aborts,
    input  ready
  );

  modport sink (
    input  valid, command, dup_ack_count, peer_window, timeout_aborts,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/reno_res_if.sv @@
// Result request channel of the Reno congestion window core.
// Depends on reno_pkg for field widths.
`default_nettype none

interface reno_res_if;
  import reno_pkg::*;

  logic            valid;
  logic            ready;
  logic [WinW-1:0] window;
  logic [WinW-1:0] threshold;
  logic [RtxW-1:0] retransmit;
  logic            try_send;
  logic            after_timeout;

  modport source (
    output valid, window, threshold, retransmit, try_send, after_timeout,
    input  ready
  );

  modport sink (
    input  valid, window, threshold, retransmit, try_send, after_timeout,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/reno_cfg_regs.sv @@
// Configuration registers of the Reno congestion window core.
// Depends on reno_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module reno_cfg_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [reno_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [reno_pkg::WinW-1:0]    cfg_data_i,
  output reno_pkg::cfg_t                cfg_o
);
  import reno_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mss      <= MSS_RST;
      cfg_q.init_wnd <= INIT_WND_RST;
      cfg_q.init_thr <= INIT_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MSS:      cfg_q.mss      <= cfg_data_i[MssW-1:0];
        CFG_INIT_WND: cfg_q.init_wnd <= cfg_data_i;
        CFG_INIT_THR: cfg_q.init_thr <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/reno_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Depends on reno_pkg for the window width.
`default_nettype none

module reno_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [reno_pkg::WinW-1:0] dividend_i,
  input  wire logic [reno_pkg::WinW-1:0] divisor_i,
  output logic                       done_o,
  output logic [reno_pkg::WinW-1:0]  quotient_o
);
  import reno_pkg::*;

  localparam int unsigned CntW = $clog2(WinW);

  logic [WinW-1:0] rem_q, rem_d;
  logic [WinW-1:0] quo_q, quo_d;
  logic [WinW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [WinW:0]   trial;
  logic [WinW:0]   diff;
  logic            fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, quo_q[WinW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? diff[WinW-1:0] : trial[WinW-1:0];
    quo_d = {quo_q[WinW-2:0], fits};
  end

  // Sequence the steps and flag the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WinW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/reno_congestion_window_core.sv @@
// Reno congestion window core: one event in, one result out.
// An accepted request goes through ST_EXEC and then ST_WB, which loads the output
// register once it is free; a congestion avoidance ACK passes ST_DGO and ST_DIV
// in between, where the serial divider computing mss*mss/cwnd sets the pace. A new
// request is taken in ST_IDLE only, even while a result still waits.
// Reset clears cwnd, ssthresh and the timeout flag and loads the configuration
// reset values. Depends on reno_pkg, reno_evt_if, reno_res_if, reno_cfg_regs, reno_div.
`default_nettype none

module reno_congestion_window_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  reno_evt_if.sink                          evt_i,
  reno_res_if.source                        res_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [reno_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [reno_pkg::WinW-1:0]    cfg_data_i
);
  import reno_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DGO  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  cfg_t cfg;

  logic [2:0]      state_q, state_d;
  logic [WinW-1:0] cwnd_q, ssth_q;
  logic            flag_q;

  logic [CmdW-1:0] cmd_q;
  logic [DupW-1:0] dups_q;
  logic [WinW-1:0] peer_q;
  logic            aborts_q;
  logic            need_div_q;

  logic [WinW-1:0] thr_q;
  logic [MssW+1:0] mss3_q;
  logic [WinW-1:0] prod_q;

  logic            out_valid_q;
  logic [WinW-1:0] out_wnd_q, out_thr_q;
  logic [RtxW-1:0] out_rtx_q;
  logic            out_send_q;
  logic            out_flag_q;

  logic            evt_acc;
  logic            wb_go;
  logic            div_done;
  logic [WinW-1:0] div_quo;
  logic [WinW-1:0] divisor;
  logic [WinW-1:0] incr;

  logic [WinW-1:0] flight;
  logic [WinW:0]   floor2;
  logic [WinW-1:0] thr_d;

  logic [WinW-1:0] add_a, add_b;
  logic [WinW:0]   add_sum;
  logic [WinW-1:0] add_sat;

  logic [WinW-1:0] cwnd_d, ssth_d;
  logic            flag_d;
  logic [RtxW-1:0] rtx_d;
  logic            send_d;

  reno_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign divisor = (cwnd_q == '0) ? WinW'(1) : cwnd_q;

  reno_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DGO),
    .dividend_i (prod_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_acc     = evt_i.valid && evt_i.ready;
  assign wb_go       = (state_q == ST_WB) && (!out_valid_q || res_o.ready);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (evt_acc) state_d = ST_EXEC;
      ST_EXEC: state_d = need_div_q ? ST_DGO : ST_WB;
      ST_DGO:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_WB;
      ST_WB:   if (wb_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Capture the event request
  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      cmd_q      <= evt_i.command;
      dups_q     <= evt_i.dup_ack_count;
      peer_q     <= evt_i.peer_window;
      aborts_q   <= evt_i.timeout_aborts;
      need_div_q <= (evt_i.command == CMD_NEW_ACK) &&
                    (evt_i.dup_ack_count < DUP_THRESH) && !(cwnd_q < ssth_q);
    end
  end

  // Threshold rule: max(min(cwnd, peer) / 2, 2 * mss)
  always_comb begin
    flight = (cwnd_q < peer_q) ? cwnd_q : peer_q;
    floor2 = (WinW + 1)'({cfg.mss, 1'b0});
    thr_d  = ({1'b0, flight >> 1} > floor2) ? (flight >> 1) : floor2[WinW-1:0];
  end

  // Register the threshold, 3*mss and mss*mss for the write-back
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      thr_q  <= thr_d;
      mss3_q <= (MssW + 2)'({cfg.mss, 1'b0}) + (MssW + 2)'(cfg.mss);
      prod_q <= WinW'(cfg.mss) * WinW'(cfg.mss);
    end
  end

  assign incr = (div_quo == '0) ? WinW'(1) : div_quo;

  // Select the operands of the saturating window adder
  always_comb begin
    add_a = cwnd_q;
    add_b = WinW'(cfg.mss);
    if (cmd_q == CMD_DUP_ACK && dups_q == DUP_THRESH) begin
      add_a = thr_q;
      add_b = WinW'(mss3_q);
    end else if (need_div_q) begin
      add_b = incr;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    add_sat = add_sum[WinW] ? '1 : add_sum[WinW-1:0];
  end

  // Work out the state update and the result fields
  always_comb begin
    cwnd_d = cwnd_q;
    ssth_d = ssth_q;
    flag_d = flag_q;
    rtx_d  = RTX_NONE;
    send_d = 1'b0;
    case (cmd_q)
      CMD_TIMEOUT: begin
        if (!aborts_q) begin
          ssth_d = thr_q;
          cwnd_d = WinW'(cfg.mss);
          flag_d = 1'b1;
          rtx_d  = RTX_TIMEOUT;
        end
      end
      CMD_NEW_ACK: begin
        send_d = 1'b1;
        if (dups_q >= DUP_THRESH) begin
          cwnd_d = ssth_q;
        end else begin
          cwnd_d = add_sat;
        end
      end
      CMD_DUP_ACK: begin
        if (dups_q == DUP_THRESH) begin
          ssth_d = thr_q;
          cwnd_d = add_sat;
          rtx_d  = RTX_FAST;
        end else if (dups_q > DUP_THRESH) begin
          cwnd_d = add_sat;
          send_d = 1'b1;
        end
      end
      CMD_START: begin
        cwnd_d = cfg.init_wnd;
        ssth_d = cfg.init_thr;
        flag_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Hold control state and publish the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cwnd_q      <= '0;
      ssth_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wb_go) begin
        cwnd_q      <= cwnd_d;
        ssth_q      <= ssth_d;
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      out_wnd_q  <= cwnd_d;
      out_thr_q  <= ssth_d;
      out_rtx_q  <= rtx_d;
      out_send_q <= send_d;
      out_flag_q <= flag_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.window        = out_wnd_q;
  assign res_o.threshold     = out_thr_q;
  assign res_o.retransmit    = out_rtx_q;
  assign res_o.try_send      = out_send_q;
  assign res_o.after_timeout = out_flag_q;

endmodule

`default_nettype wire
